FILE: hdl/nfps_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Nearest-first pending selector package
// Field widths, command codes and the control and status bundles that pass
// between the top level and the row of slot cells.
// ----------------------------------------------------------------------------
package nfps_pkg;

   // Fixed field widths of the command, result and register ports.
   localparam int KIND_W = 2;
   localparam int SLOT_W = 7;
   localparam int CFG_W  = 8;

   // Command codes carried on the kind field.
   typedef enum logic [KIND_W-1:0] {
      KIND_BEGIN   = 2'd0,
      KIND_FOCUS   = 2'd1,
      KIND_REQUEST = 2'd2,
      KIND_CANCEL  = 2'd3
   } kind_type;

   // Broadcast from the controller to every cell.
   typedef struct packed {
      logic load;       // place both search tokens at the start slot
      logic shift;      // move the tokens one slot outward
      logic clear;      // forget all served marks
      logic take_up;    // mark the slot under the upward token served
      logic take_down;  // mark the slot under the downward token served
   } cell_ctrl_type;

   // Per-cell report back to the controller.
   typedef struct packed {
      logic hit_up;     // upward token sits on an unserved slot of the run
      logic hit_down;   // downward token sits on an unserved slot of the run
   } cell_status_type;

endpackage
`default_nettype wire

FILE: hdl/nearest_first_pending_selector.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Nearest-first pending selector
// Hands out the slots of a run one at a time, nearest to a focus position
// first, searching with two tokens that sweep outward through a row of cells.
// ----------------------------------------------------------------------------
// Usage:
//   Commands enter on req_kind / req_position and transfer at a clock edge
//   with start high and busy low. Begin, focus and cancel commands finish in
//   the cycle they are taken and give no result. A request gives exactly one
//   result, shown for one cycle with rsp_strobe high; the receiver cannot
//   hold it off.
//   The slot count register is written on the csr_ channel, which is always
//   ready; write it only while no request is in progress.
//   A request that cannot be served answers in the cycle after it is
//   taken. Otherwise the tokens test one distance per cycle, and a request
//   answers once a token finds a free slot, or once the tokens have covered
//   the whole run with nothing free. busy is high during the sweep; the next
//   command can be taken in the cycle its result is shown.
//   Reset clears the served map, the focus, the count of remaining slots,
//   the cancel flag, the run state and the slot count register.
// ----------------------------------------------------------------------------
module nearest_first_pending_selector #(
   parameter int SLOTS = 128
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   // command channel
   input  wire logic                        start,
   output logic                             busy,
   input  wire logic [nfps_pkg::KIND_W-1:0] req_kind,
   input  wire logic [nfps_pkg::SLOT_W-1:0] req_position,
   // result channel
   output logic                             rsp_strobe,
   output logic [nfps_pkg::SLOT_W-1:0]      rsp_slot,
   output logic                             rsp_slot_valid,
   output logic                             rsp_run_over,
   // register write channel
   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire logic [nfps_pkg::CFG_W-1:0]  csr_data
);

   localparam int IW = (SLOTS > (1 << nfps_pkg::SLOT_W)) ? $clog2(SLOTS)
                                                          : nfps_pkg::SLOT_W;
   localparam int CW = IW + 1;
   localparam logic [CW-1:0] SLOTS_C = CW'(SLOTS);

   typedef enum logic {
      ST_IDLE,
      ST_SEARCH
   } state_type;

   state_type                 state_ff, state_in;
   logic [nfps_pkg::CFG_W-1:0] slide_count_ff, slide_count_in;
   logic [nfps_pkg::SLOT_W-1:0] focus_ff, focus_in;
   logic [nfps_pkg::CFG_W-1:0] remaining_ff, remaining_in;
   logic                      cancel_ff, cancel_in;
   logic                      run_active_ff, run_active_in;
   logic [IW-1:0]             start_ff, start_in;
   logic [IW-1:0]             dist_ff, dist_in;
   logic                      rsp_strobe_ff, rsp_strobe_in;
   logic [nfps_pkg::SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic                      rsp_slot_valid_ff, rsp_slot_valid_in;
   logic                      rsp_run_over_ff, rsp_run_over_in;

   logic                      take;
   logic [CW-1:0]             count;
   logic [CW-1:0]             last;
   logic [IW-1:0]             focus_ext;
   logic [IW-1:0]             start_pick;
   logic                      can_serve;
   logic                      any_up;
   logic                      any_down;
   logic [IW-1:0]             pick_up;
   logic [IW-1:0]             pick_down;
   nfps_pkg::cell_ctrl_type   ctrl;
   logic [SLOTS-1:0]          up_vec;
   logic [SLOTS-1:0]          down_vec;
   logic [SLOTS-1:0]          hit_up_vec;
   logic [SLOTS-1:0]          hit_down_vec;

   // Handshakes.
   assign busy      = (state_ff == ST_SEARCH);
   assign take      = start && !busy;
   assign csr_ready = 1'b1;

   // Live run length, clamped to the number of cells, and the clamped focus.
   assign count      = (CW'(slide_count_ff) > SLOTS_C) ? SLOTS_C : CW'(slide_count_ff);
   assign last       = count - CW'(1);
   assign focus_ext  = IW'(focus_ff);
   assign start_pick = (CW'(focus_ext) > last) ? last[IW-1:0] : focus_ext;
   assign can_serve  = run_active_ff && !cancel_ff && (remaining_ff != '0) &&
                       (count != '0);

   // Hits reported by the row; the downward token only counts past distance 0.
   assign any_up    = |hit_up_vec;
   assign any_down  = (|hit_down_vec) && (dist_ff != '0);
   assign pick_up   = start_ff + dist_ff;
   assign pick_down = start_ff - dist_ff;

   // Broadcast to the cells.
   always_comb begin
      ctrl           = '0;
      ctrl.load      = take && (req_kind == nfps_pkg::KIND_REQUEST) && can_serve;
      ctrl.clear     = take && (req_kind == nfps_pkg::KIND_BEGIN) &&
                       !run_active_ff && !cancel_ff;
      if (state_ff == ST_SEARCH) begin
         ctrl.take_up   = any_up;
         ctrl.take_down = !any_up && any_down;
         ctrl.shift     = !any_up && !any_down;
      end
   end

   // Row of slot cells; tokens move up and down between neighbors.
   for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      logic up_prev;
      logic down_next;
      nfps_pkg::cell_status_type status;

      if (i == 0) begin : g_first
         assign up_prev = 1'b0;
      end else begin : g_inner_up
         assign up_prev = up_vec[i-1];
      end
      if (i == SLOTS - 1) begin : g_last
         assign down_next = 1'b0;
      end else begin : g_inner_down
         assign down_next = down_vec[i+1];
      end

      nfps_cell #(
         .IW    (IW),
         .INDEX (i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .start_idx (start_in),
         .count     (count),
         .up_prev   (up_prev),
         .down_next (down_next),
         .up_tok    (up_vec[i]),
         .down_tok  (down_vec[i]),
         .status    (status)
      );

      assign hit_up_vec[i]   = status.hit_up;
      assign hit_down_vec[i] = status.hit_down;
   end

   // Next state of the controller and its registered outputs.
   always_comb begin
      state_in          = state_ff;
      slide_count_in    = slide_count_ff;
      focus_in          = focus_ff;
      remaining_in      = remaining_ff;
      cancel_in         = cancel_ff;
      run_active_in     = run_active_ff;
      start_in          = start_ff;
      dist_in           = dist_ff;
      rsp_strobe_in     = 1'b0;
      rsp_slot_in       = rsp_slot_ff;
      rsp_slot_valid_in = rsp_slot_valid_ff;
      rsp_run_over_in   = rsp_run_over_ff;

      if (csr_valid && csr_ready) begin
         slide_count_in = csr_data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (take) begin
               unique case (req_kind)
                  nfps_pkg::KIND_BEGIN: begin
                     if (!run_active_ff && !cancel_ff) begin
                        remaining_in  = count[nfps_pkg::CFG_W-1:0];
                        run_active_in = 1'b1;
                     end
                  end
                  nfps_pkg::KIND_FOCUS: begin
                     focus_in = req_position;
                  end
                  nfps_pkg::KIND_CANCEL: begin
                     cancel_in = 1'b1;
                  end
                  default: begin
                     if (can_serve) begin
                        start_in = start_pick;
                        dist_in  = '0;
                        state_in = ST_SEARCH;
                     end else begin
                        run_active_in     = 1'b0;
                        rsp_strobe_in     = 1'b1;
                        rsp_slot_in       = '0;
                        rsp_slot_valid_in = 1'b0;
                        rsp_run_over_in   = 1'b1;
                     end
                  end
               endcase
            end
         end
         ST_SEARCH: begin
            priority if (any_up || any_down) begin
               remaining_in      = remaining_ff - nfps_pkg::CFG_W'(1);
               rsp_strobe_in     = 1'b1;
               rsp_slot_in       = any_up ? pick_up[nfps_pkg::SLOT_W-1:0]
                                          : pick_down[nfps_pkg::SLOT_W-1:0];
               rsp_slot_valid_in = 1'b1;
               rsp_run_over_in   = 1'b0;
               state_in          = ST_IDLE;
            end else if (CW'(dist_ff) == last) begin
               run_active_in     = 1'b0;
               rsp_strobe_in     = 1'b1;
               rsp_slot_in       = '0;
               rsp_slot_valid_in = 1'b0;
               rsp_run_over_in   = 1'b1;
               state_in          = ST_IDLE;
            end else begin
               dist_in = dist_ff + IW'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         slide_count_ff    <= '0;
         focus_ff          <= '0;
         remaining_ff      <= '0;
         cancel_ff         <= 1'b0;
         run_active_ff     <= 1'b0;
         start_ff          <= '0;
         dist_ff           <= '0;
         rsp_strobe_ff     <= 1'b0;
         rsp_slot_ff       <= '0;
         rsp_slot_valid_ff <= 1'b0;
         rsp_run_over_ff   <= 1'b0;
      end else begin
         state_ff          <= state_in;
         slide_count_ff    <= slide_count_in;
         focus_ff          <= focus_in;
         remaining_ff      <= remaining_in;
         cancel_ff         <= cancel_in;
         run_active_ff     <= run_active_in;
         start_ff          <= start_in;
         dist_ff           <= dist_in;
         rsp_strobe_ff     <= rsp_strobe_in;
         rsp_slot_ff       <= rsp_slot_in;
         rsp_slot_valid_ff <= rsp_slot_valid_in;
         rsp_run_over_ff   <= rsp_run_over_in;
      end
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_slot       = rsp_slot_ff;
   assign rsp_slot_valid = rsp_slot_valid_ff;
   assign rsp_run_over   = rsp_run_over_ff;

   // Each search token exists in at most one cell.
   a_up_single: assert property (@(posedge clock) disable iff (reset)
      $onehot0(up_vec))
      else $error("upward search token present in more than one cell");

   a_down_single: assert property (@(posedge clock) disable iff (reset)
      $onehot0(down_vec))
      else $error("downward search token present in more than one cell");

   // A result either hands out a slot or reports the end of the run.
   a_rsp_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_slot_valid != rsp_run_over))
      else $error("result is neither a slot nor an end of run");

   // Reporting the end of the run leaves no run active.
   a_run_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_run_over) |-> !run_active_ff)
      else $error("run still active after end of run was reported");

   // A handed out slot uses up one of the remaining slots.
   a_count_down: assert property (@(posedge clock) disable iff (reset)
      (busy && (any_up || any_down)) |=> (remaining_ff == $past(remaining_ff) -
                                          nfps_pkg::CFG_W'(1)))
      else $error("remaining count not decremented after a slot transfer");

endmodule
`default_nettype wire

FILE: hdl/nfps_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Slot cell
// Holds the served mark of one slot and the two search tokens that sweep
// outward from the focus, one slot per cycle until a hit, through the cells.
// ----------------------------------------------------------------------------
module nfps_cell #(
   parameter int IW    = 7,
   parameter int INDEX = 0
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire nfps_pkg::cell_ctrl_type  ctrl,
   input  wire logic [IW-1:0]            start_idx,
   input  wire logic [IW:0]              count,
   input  wire logic                     up_prev,
   input  wire logic                     down_next,
   output logic                          up_tok,
   output logic                          down_tok,
   output nfps_pkg::cell_status_type     status
);

   localparam logic [IW:0] INDEX_C = (IW+1)'(INDEX);

   logic served_ff, served_in;
   logic up_ff, up_in;
   logic down_ff, down_in;
   logic is_start;
   logic in_run;

   // Position checks against the start slot and the length of the run.
   assign is_start = (INDEX_C[IW-1:0] == start_idx);
   assign in_run   = (INDEX_C < count);

   // Next state of the served mark and the two tokens.
   always_comb begin
      served_in = served_ff;
      if (ctrl.clear) begin
         served_in = 1'b0;
      end else if ((ctrl.take_up && up_ff) || (ctrl.take_down && down_ff)) begin
         served_in = 1'b1;
      end

      up_in   = up_ff;
      down_in = down_ff;
      if (ctrl.load) begin
         up_in   = is_start;
         down_in = is_start;
      end else if (ctrl.shift) begin
         up_in   = up_prev;
         down_in = down_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         served_ff <= 1'b0;
         up_ff     <= 1'b0;
         down_ff   <= 1'b0;
      end else begin
         served_ff <= served_in;
         up_ff     <= up_in;
         down_ff   <= down_in;
      end
   end

   // A token reports a hit when its slot is inside the run and still free.
   assign up_tok          = up_ff;
   assign down_tok        = down_ff;
   assign status.hit_up   = up_ff && !served_ff && in_run;
   assign status.hit_down = down_ff && !served_ff && in_run;

endmodule
`default_nettype wire

FILE: dv/nearest_first_pending_selector_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest-first pending selector testbench
// Sends begin, focus, request and cancel commands through the start/busy
// port and changes the slot count between phases. A scoreboard keeps its own
// copy of the served map and run state, predicts each request's answer and
// compares it field by field with the result seen on the strobe.
// ----------------------------------------------------------------------------
module nearest_first_pending_selector_test;

   localparam int SLOT_COUNT    = 128;
   localparam int TOTAL_ITEMS   = 1850;
   localparam int TAIL_ITEMS    = 5;
   localparam int SETTLE_CYCLES = 4;
   localparam int DRAIN_LIMIT   = 2000;

   // One expected answer to a request.
   typedef struct {
      logic [nfps_pkg::SLOT_W-1:0] slot;
      logic                        slot_valid;
      logic                        run_over;
   } slot_answer_type;

   // Tracks the selector's state and the answers still owed by the block.
   class selector_scoreboard;
      bit                          served [SLOT_COUNT];
      bit [nfps_pkg::SLOT_W-1:0]   focus;
      bit [nfps_pkg::CFG_W-1:0]    remaining;
      bit [nfps_pkg::CFG_W-1:0]    slide_count;
      bit                          cancelled;
      bit                          run_active;
      slot_answer_type             pending_answers [$];
      int                          mismatches;

      // The live run length, clamped to the number of slots.
      function int unsigned run_length();
         return (slide_count > SLOT_COUNT) ? SLOT_COUNT : slide_count;
      endfunction

      // Search outward from the clamped focus: the focus itself, then one
      // above, one below, two above, and so on.
      function bit find_nearest_free(input int unsigned n, output int unsigned pick);
         int unsigned origin;
         int unsigned d;
         pick = 0;
         if (n == 0) return 0;
         origin = (focus > n - 1) ? n - 1 : focus;
         for (d = 0; d < n; d++) begin
            if (origin + d < n && !served[origin + d]) begin
               pick = origin + d;
               return 1;
            end
            if (d != 0 && d <= origin && !served[origin - d]) begin
               pick = origin - d;
               return 1;
            end
         end
         return 0;
      endfunction

      // Apply one accepted command; a request queues the answer it must give.
      function void note_command(nfps_pkg::kind_type kind,
                                 logic [nfps_pkg::SLOT_W-1:0] position);
         slot_answer_type answer;
         int unsigned     pick;
         case (kind)
            nfps_pkg::KIND_BEGIN: begin
               if (!run_active && !cancelled) begin
                  foreach (served[i]) served[i] = 1'b0;
                  remaining  = run_length();
                  run_active = 1'b1;
               end
            end
            nfps_pkg::KIND_FOCUS: begin
               focus = position;
            end
            nfps_pkg::KIND_CANCEL: begin
               cancelled = 1'b1;
            end
            default: begin
               if (run_active && !cancelled && remaining != 0 &&
                   find_nearest_free(run_length(), pick)) begin
                  served[pick]      = 1'b1;
                  remaining         = remaining - 1'b1;
                  answer.slot       = nfps_pkg::SLOT_W'(pick);
                  answer.slot_valid = 1'b1;
                  answer.run_over   = 1'b0;
               end else begin
                  run_active        = 1'b0;
                  answer.slot       = '0;
                  answer.slot_valid = 1'b0;
                  answer.run_over   = 1'b1;
               end
               pending_answers = {pending_answers, answer};
            end
         endcase
      endfunction

      task report_mismatch(string what);
         $display("%0t ns mismatch: %s", $time, what);
         mismatches++;
      endtask

      // Compare one result transfer with the oldest expected answer.
      task check_answer(logic [nfps_pkg::SLOT_W-1:0] slot, logic slot_valid,
                        logic run_over);
         slot_answer_type want;
         if (pending_answers.size() == 0) begin
            report_mismatch($sformatf("unrequested result slot %0d valid %b over %b",
                                      slot, slot_valid, run_over));
            return;
         end
         want = pending_answers.pop_front();
         if (slot !== want.slot)
            report_mismatch($sformatf("slot %0d, expected %0d", slot, want.slot));
         if (slot_valid !== want.slot_valid)
            report_mismatch($sformatf("slot_valid %b, expected %b", slot_valid,
                                      want.slot_valid));
         if (run_over !== want.run_over)
            report_mismatch($sformatf("run_over %b, expected %b", run_over,
                                      want.run_over));
      endtask

      // Any answer still owed at the end of the run is a failure.
      task flush_leftovers();
         slot_answer_type want;
         while (pending_answers.size() != 0) begin
            want = pending_answers.pop_front();
            report_mismatch($sformatf("missing result slot %0d valid %b over %b",
                                      want.slot, want.slot_valid, want.run_over));
         end
      endtask
   endclass

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          start = 1'b0;
   logic                          busy;
   logic [nfps_pkg::KIND_W-1:0]   req_kind = '0;
   logic [nfps_pkg::SLOT_W-1:0]   req_position = '0;
   logic                          rsp_strobe;
   logic [nfps_pkg::SLOT_W-1:0]   rsp_slot;
   logic                          rsp_slot_valid;
   logic                          rsp_run_over;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [nfps_pkg::CFG_W-1:0]    csr_data = '0;

   selector_scoreboard            sb;
   bit                            gaps_on;
   int                            burst_left;
   int                            items_sent;
   logic [nfps_pkg::CFG_W-1:0]    current_count;

   nearest_first_pending_selector #(
      .SLOTS(SLOT_COUNT)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_kind       (req_kind),
      .req_position   (req_position),
      .rsp_strobe     (rsp_strobe),
      .rsp_slot       (rsp_slot),
      .rsp_slot_valid (rsp_slot_valid),
      .rsp_run_over   (rsp_run_over),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data       (csr_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Hard stop in case the block stops answering.
   initial begin
      #8_000_000;
      $display("nearest_first_pending_selector regression: fail");
      $finish;
   end

   // Watch every transfer at the rising edge: results first, then register
   // writes, then accepted commands.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) sb.check_answer(rsp_slot, rsp_slot_valid, rsp_run_over);
         if (csr_valid && csr_ready) sb.slide_count = csr_data;
         if (start && !busy) sb.note_command(nfps_pkg::kind_type'(req_kind), req_position);
      end
   end

   // Present one command and hold it until the block takes it. Between
   // bursts, when gaps are enabled, the sender pauses with start low.
   task automatic send_command(nfps_pkg::kind_type kind,
                               logic [nfps_pkg::SLOT_W-1:0] position);
      if (gaps_on && burst_left == 0) begin
         repeat ($urandom_range(1, 8)) begin
            @(negedge clock);
            start <= 1'b0;
         end
         burst_left = $urandom_range(1, 20);
      end
      @(negedge clock);
      start        <= 1'b1;
      req_kind     <= kind;
      req_position <= position;
      do @(posedge clock); while (busy);
      if (burst_left > 0) burst_left--;
      items_sent++;
   endtask

   // Stop sending and wait until the block owes nothing.
   task automatic settle();
      @(negedge clock);
      start <= 1'b0;
      while (sb.pending_answers.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_slide_count(logic [nfps_pkg::CFG_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      current_count = value;
   endtask

   // Half the focus values land inside the run, the rest anywhere.
   function automatic logic [nfps_pkg::SLOT_W-1:0] random_focus();
      int unsigned span;
      span = (current_count > SLOT_COUNT) ? SLOT_COUNT : current_count;
      if (span != 0 && $urandom_range(0, 1) == 1)
         return nfps_pkg::SLOT_W'($urandom_range(0, span - 1));
      return nfps_pkg::SLOT_W'($urandom_range(0, SLOT_COUNT - 1));
   endfunction

   initial begin
      int unsigned                 choice;
      int unsigned                 roll;
      int unsigned                 span;
      logic [nfps_pkg::CFG_W-1:0]  value;
      int                          waited;

      sb            = new();
      gaps_on       = 1'b0;
      burst_left    = 0;
      items_sent    = 0;
      current_count = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // A request with no run active.
      send_command(nfps_pkg::KIND_REQUEST, 7'h7F);
      settle();

      // Short run with the focus beyond its end: served top down, then over.
      write_slide_count(8'd5);
      send_command(nfps_pkg::KIND_FOCUS, 7'd127);
      send_command(nfps_pkg::KIND_BEGIN, 7'd0);
      send_command(nfps_pkg::KIND_BEGIN, 7'd0);
      repeat (6) send_command(nfps_pkg::KIND_REQUEST, 7'd0);
      settle();

      // A run with nothing in it ends at its first request.
      write_slide_count(8'd0);
      send_command(nfps_pkg::KIND_BEGIN, 7'd0);
      send_command(nfps_pkg::KIND_REQUEST, 7'd0);
      settle();

      // Full-size run with the focus at both ends and the middle.
      write_slide_count(8'd128);
      send_command(nfps_pkg::KIND_FOCUS, 7'd0);
      send_command(nfps_pkg::KIND_BEGIN, 7'd0);
      send_command(nfps_pkg::KIND_REQUEST, 7'd0);
      send_command(nfps_pkg::KIND_REQUEST, 7'd0);
      send_command(nfps_pkg::KIND_FOCUS, 7'd127);
      send_command(nfps_pkg::KIND_REQUEST, 7'd0);
      send_command(nfps_pkg::KIND_FOCUS, 7'd64);
      send_command(nfps_pkg::KIND_REQUEST, 7'd0);
      settle();

      // Shrink the count mid-run below every free slot.
      write_slide_count(8'd2);
      send_command(nfps_pkg::KIND_REQUEST, 7'd0);

      // Random phases: a new count, usually a new run, then a mix of
      // requests, focus moves and begins. Some runs carry over a count change.
      while (items_sent < TOTAL_ITEMS - TAIL_ITEMS) begin
         settle();
         choice = $urandom_range(0, 19);
         case (choice)
            0:       value = 8'd0;
            1:       value = 8'd128;
            2:       value = 8'd255;
            3:       value = nfps_pkg::CFG_W'($urandom_range(129, 254));
            4:       value = 8'd127;
            5:       value = 8'd1;
            default: value = nfps_pkg::CFG_W'($urandom_range(2, 16));
         endcase
         write_slide_count(value);
         span       = (value > SLOT_COUNT) ? SLOT_COUNT : value;
         gaps_on    = ($urandom_range(0, 3) != 0);
         burst_left = 0;
         if ($urandom_range(0, 3) != 0)
            send_command(nfps_pkg::KIND_BEGIN, nfps_pkg::SLOT_W'($urandom));
         if ($urandom_range(0, 7) == 0) begin
            // Drain the whole run and two past it.
            repeat (span + 2) begin
               if ($urandom_range(0, 4) == 0)
                  send_command(nfps_pkg::KIND_FOCUS, random_focus());
               send_command(nfps_pkg::KIND_REQUEST, nfps_pkg::SLOT_W'($urandom));
            end
         end else begin
            repeat ($urandom_range(4, 30)) begin
               roll = $urandom_range(0, 99);
               if (roll < 55) begin
                  send_command(nfps_pkg::KIND_REQUEST, nfps_pkg::SLOT_W'($urandom));
               end else if (roll < 82) begin
                  send_command(nfps_pkg::KIND_FOCUS, random_focus());
               end else begin
                  send_command(nfps_pkg::KIND_BEGIN, nfps_pkg::SLOT_W'($urandom));
               end
            end
         end
      end

      // Cancel is sticky until reset, so it comes last.
      settle();
      write_slide_count(8'd8);
      gaps_on = 1'b0;
      send_command(nfps_pkg::KIND_BEGIN, 7'd0);
      send_command(nfps_pkg::KIND_CANCEL, 7'h55);
      send_command(nfps_pkg::KIND_REQUEST, 7'd0);
      send_command(nfps_pkg::KIND_BEGIN, 7'd0);
      send_command(nfps_pkg::KIND_REQUEST, 7'd0);

      @(negedge clock);
      start <= 1'b0;
      waited = 0;
      while (sb.pending_answers.size() != 0 && waited < DRAIN_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES * 4) @(posedge clock);
      sb.flush_leftovers();
      if (sb.mismatches == 0) begin
         $display("nearest_first_pending_selector regression: pass");
      end else begin
         $display("nearest_first_pending_selector regression: fail");
      end
      $finish;
   end

endmodule
